// ----- hdl/pat_pkg.sv -----
// Package for the positional array table: word types, operation and status codes,
// sequencer states and default sizes. No dependencies.
`default_nettype none

package pat_pkg;

  localparam int DEPTH_DEF = 16;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_FULL   = 2'd1;
  localparam logic [1:0] STS_BADPOS = 2'd2;
  localparam logic [1:0] STS_MISS   = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] found_position;
    logic [4:0] fill_count;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UP   = 4'b0010,
    ST_DN   = 4'b0100,
    ST_SCAN = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/positional_array_table_core.sv -----
// Top level of the positional array table: sequencer and entry store.
// Depends on pat_pkg, pat_ctrl and pat_mem.
//
//   channel   ports                    handshake
//   input     start, busy, in_word     taken when start is high and busy is low
//   result    out_strobe, out_word     one word, one cycle, taken when shown
//
// Rejected commands, deletes of the last entry and searches of an empty table
// answer in the cycle after acceptance and leave busy low.
// Insert at position p moves the entries from the last down to p up by one, then
// writes the value; delete moves the entries behind p down by one; search reads
// from the first entry to a match or the last. All use the store's single read port.
// Reset clears the fill count and the sequencer; the entry store needs no clearing.
// Results cannot be stalled; the sequencer never waits on the receiver.
`default_nettype none

module positional_array_table_core #(
  parameter int DEPTH = pat_pkg::DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire pat_pkg::in_word_t in_word,
  output logic                   out_strobe,
  output pat_pkg::out_word_t     out_word
);
  import pat_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  pat_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  pat_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ----- hdl/pat_mem.sv -----
// Entry store of the positional array table: one write port, one read port,
// registered read data. Depends on pat_pkg.
`default_nettype none

module pat_mem #(
  parameter int DEPTH = pat_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rdata
);
  import pat_pkg::*;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hdl/pat_ctrl.sv -----
// Sequencer of the positional array table: decodes commands, keeps the fill count,
// walks the entry store for shifts and scans. Depends on pat_pkg.
`default_nettype none

module pat_ctrl #(
  parameter int DEPTH = pat_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire pat_pkg::in_word_t  in_word,
  output logic                    out_strobe,
  output pat_pkg::out_word_t      out_word,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic [31:0]             mem_wdata,
  output logic                    mem_re,
  output logic [AW-1:0]           mem_raddr,
  input  wire logic [31:0]        mem_rdata
);
  import pat_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > 5) ? CW : 5) + 1;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic [AW-1:0]   bound_r, bound_nxt;
  logic [AW-1:0]   pend_addr_r, pend_addr_nxt;
  logic            more_r, more_nxt;
  logic            pend_r, pend_nxt;
  logic [31:0]     val_r, val_nxt;
  logic            out_strobe_r, out_strobe_nxt;
  out_word_t       out_word_r, out_word_nxt;

  logic [XW-1:0]   pos_x, cnt_x, cnt_nxt_x, pos_m1_x, found_x;
  logic [CW-1:0]   cnt_dec, cnt_inc;
  logic [AW-1:0]   cnt_m1;
  logic            emit;
  logic [1:0]      emit_status;
  logic [4:0]      emit_found;
  logic            last_rd;

  assign pos_x     = XW'(in_word.position);
  assign cnt_x     = XW'(cnt_r);
  assign pos_m1_x  = pos_x - XW'(1);
  assign cnt_dec   = cnt_r - CW'(1);
  assign cnt_inc   = cnt_r + CW'(1);
  assign cnt_m1    = cnt_dec[AW-1:0];
  assign found_x   = XW'(pend_addr_r) + XW'(1);
  assign cnt_nxt_x = XW'(cnt_nxt);
  assign last_rd   = (ptr_r == bound_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    bound_nxt     = bound_r;
    more_nxt      = more_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    val_nxt       = val_r;
    emit          = 1'b0;
    emit_status   = STS_OK;
    emit_found    = 5'd0;
    mem_we        = 1'b0;
    mem_waddr     = pend_addr_r;
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = ptr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          val_nxt = in_word.value;
          priority if (in_word.action == ACT_INSERT) begin
            priority if (cnt_x == XW'(DEPTH)) begin
              emit        = 1'b1;
              emit_status = STS_FULL;
            end else if (pos_x == XW'(0) || pos_x > cnt_x + XW'(1)) begin
              emit        = 1'b1;
              emit_status = STS_BADPOS;
            end else begin
              state_nxt = ST_UP;
              ptr_nxt   = cnt_m1;
              bound_nxt = pos_m1_x[AW-1:0];
              more_nxt  = (pos_x <= cnt_x);
            end
          end else if (in_word.action == ACT_DELETE) begin
            priority if (pos_x == XW'(0) || pos_x > cnt_x) begin
              emit        = 1'b1;
              emit_status = STS_BADPOS;
            end else if (pos_x == cnt_x) begin
              cnt_nxt = cnt_dec;
              emit    = 1'b1;
            end else begin
              state_nxt = ST_DN;
              ptr_nxt   = pos_x[AW-1:0];
              bound_nxt = cnt_m1;
              more_nxt  = 1'b1;
            end
          end else if (in_word.action == ACT_SEARCH) begin
            if (cnt_r == CW'(0)) begin
              emit        = 1'b1;
              emit_status = STS_MISS;
            end else begin
              state_nxt = ST_SCAN;
              ptr_nxt   = '0;
              bound_nxt = cnt_m1;
              more_nxt  = 1'b1;
            end
          end else begin
            emit        = 1'b1;
            emit_status = STS_BADPOS;
          end
        end
      end
      ST_UP: begin
        mem_re    = more_r;
        mem_we    = pend_r;
        mem_waddr = pend_addr_r + AW'(1);
        if (!more_r && !pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = bound_r;
          mem_wdata = val_r;
          cnt_nxt   = cnt_inc;
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DN: begin
        mem_re    = more_r;
        mem_we    = pend_r;
        mem_waddr = pend_addr_r - AW'(1);
        if (!more_r) begin
          cnt_nxt   = cnt_dec;
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        mem_re = more_r;
        priority if (pend_r && mem_rdata == val_r) begin
          emit       = 1'b1;
          emit_found = found_x[4:0];
          state_nxt  = ST_IDLE;
        end else if (!more_r) begin
          emit        = 1'b1;
          emit_status = STS_MISS;
          state_nxt   = ST_IDLE;
        end else begin
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // advance the read pointer and track the word in flight
    if (mem_re) begin
      pend_nxt      = 1'b1;
      pend_addr_nxt = ptr_r;
      if (last_rd) begin
        more_nxt = 1'b0;
      end else if (state_r == ST_UP) begin
        ptr_nxt = ptr_r - AW'(1);
      end else begin
        ptr_nxt = ptr_r + AW'(1);
      end
    end
    if (state_nxt == ST_IDLE) begin
      pend_nxt = 1'b0;
    end

    out_strobe_nxt              = emit;
    out_word_nxt.status         = emit_status;
    out_word_nxt.found_position = emit_found;
    out_word_nxt.fill_count     = cnt_nxt_x[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      more_r       <= 1'b0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      more_r       <= more_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    bound_r     <= bound_nxt;
    pend_addr_r <= pend_addr_nxt;
    val_r       <= val_nxt;
    if (out_strobe_nxt) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fill count above depth");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (state_r == ST_IDLE))
    else $error("result word while sequencer busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe || busy))
    else $error("accepted word neither answered nor in progress");

  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write to the same entry in one cycle");

endmodule

`default_nettype wire
